[rtl/lifetime_bin_first_fit_placer_unit_macros.svh]
// Assertion macros for the lifetime bin first-fit placer unit
`ifndef LIFETIME_BIN_FIRST_FIT_PLACER_UNIT_MACROS_SVH
`define LIFETIME_BIN_FIRST_FIT_PLACER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define LBFF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbff check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define LBFF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbff check failed");

`endif

[rtl/lbff_pkg.sv]
// Package: sizes, payload types and internal job type of the bin placer
`default_nettype none
package lbff_pkg;

    localparam int MAX_BINS  = 64;
    localparam int MAX_STEPS = 1024;
    localparam int WORD_BITS = 64;

    localparam int WPB      = (MAX_STEPS + WORD_BITS - 1) / WORD_BITS;
    localparam int WLOG_W   = $clog2(WORD_BITS);
    localparam int WIDX_W   = (WPB > 1) ? $clog2(WPB) : 1;
    localparam int BIN_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W    = $clog2(MAX_BINS + 1);
    localparam int SIDX_W   = $clog2(MAX_STEPS);
    localparam int ADDR_W   = BIN_W + WIDX_W;

    localparam int STEP_W   = 10;
    localparam int SIZE_W   = 32;
    localparam int TAG_W    = 16;
    localparam int OBIN_W   = 6;

    localparam logic REQ_PLACE = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [STEP_W-1:0] start_step;
        logic [STEP_W-1:0] end_step;
        logic [SIZE_W-1:0] block_size;
        logic [TAG_W-1:0]  block_tag;
    } req_item_t;

    typedef struct packed {
        logic [OBIN_W-1:0] bin_index;
        logic              opened_bin;
        logic [SIZE_W-1:0] bin_size;
        logic              overflow;
        logic [TAG_W-1:0]  tag_out;
    } rsp_item_t;

    typedef struct packed {
        logic              is_clear;
        logic [WIDX_W-1:0] ws;
        logic [WIDX_W-1:0] we;
        logic [WLOG_W-1:0] lo;
        logic [WLOG_W-1:0] hi;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } job_t;

endpackage
`default_nettype wire

[rtl/lbff_front.sv]
// Front end: accept requests, normalize lifetimes, queue jobs for the back end
`default_nettype none
module lbff_front
    import lbff_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire req_item_t req,
    output logic           job_valid,
    input  wire logic      job_ready,
    output job_t           job
);

    localparam int QD = 2;

    job_t              q_reg [QD];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [STEP_W-1:0] s_raw, e_raw;
    logic [SIDX_W-1:0] s_sat, e_sat;
    job_t              new_job;
    logic              push, pop;

    always_comb
    begin
        s_raw = (req.end_step < req.start_step) ? req.end_step : req.start_step;
        e_raw = (req.end_step < req.start_step) ? req.start_step : req.end_step;
        s_sat = (32'(s_raw) >= 32'(MAX_STEPS)) ? SIDX_W'(MAX_STEPS - 1) : SIDX_W'(s_raw);
        e_sat = (32'(e_raw) >= 32'(MAX_STEPS)) ? SIDX_W'(MAX_STEPS - 1) : SIDX_W'(e_raw);
        new_job.is_clear = (req.req_type == REQ_CLEAR);
        new_job.ws       = WIDX_W'(s_sat >> WLOG_W);
        new_job.we       = WIDX_W'(e_sat >> WLOG_W);
        new_job.lo       = s_sat[WLOG_W-1:0];
        new_job.hi       = e_sat[WLOG_W-1:0];
        new_job.size     = req.block_size;
        new_job.tag      = req.block_tag;
    end

    assign req_ready = (cnt_reg != 2'(QD));
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_job;
        end
    end

endmodule
`default_nettype wire

[rtl/lbff_back.sv]
// Back end: first-fit bin search, bitmap and size update, result register
`default_nettype none
module lbff_back
    import lbff_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    output logic      job_ready,
    input  wire job_t job,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_item_t rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_MRD  = 3'd3;
    localparam logic [2:0] S_MWR  = 3'd4;
    localparam logic [2:0] S_SZ   = 3'd5;
    localparam logic [2:0] S_NEW  = 3'd6;
    localparam logic [2:0] S_RES  = 3'd7;

    logic [WORD_BITS-1:0] occ_mem [MAX_BINS * WPB];
    logic [SIZE_W-1:0]    sz_mem  [MAX_BINS];

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     bins_reg, bins_next;
    logic [BIN_W-1:0]     b_reg, b_next;
    logic [WIDX_W-1:0]    w_reg, w_next;
    job_t                 job_reg, job_next;
    rsp_item_t            res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_item_t            out_reg, out_next;
    logic [WORD_BITS-1:0] rd_reg;
    logic [SIZE_W-1:0]    sz_rd_reg;

    logic [ADDR_W-1:0]    addr;
    logic                 occ_we;
    logic [WORD_BITS-1:0] occ_wd;
    logic                 sz_we;
    logic [SIZE_W-1:0]    sz_wd;
    logic [WLOG_W-1:0]    lo_eff, hi_eff;
    logic [WORD_BITS-1:0] mask;
    logic                 last_bin, in_range;
    logic [SIZE_W-1:0]    max_size;

    assign addr      = {b_reg, w_reg};
    assign job_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        lo_eff   = (w_reg == job_reg.ws) ? job_reg.lo : '0;
        hi_eff   = (w_reg == job_reg.we) ? job_reg.hi : WLOG_W'(WORD_BITS - 1);
        mask     = ({WORD_BITS{1'b1}} << lo_eff)
                 & ({WORD_BITS{1'b1}} >> (WLOG_W'(WORD_BITS - 1) - hi_eff));
        last_bin = ((CNT_W'(b_reg) + CNT_W'(1)) == bins_reg);
        in_range = (w_reg >= job_reg.ws) && (w_reg <= job_reg.we);
        max_size = (job_reg.size > sz_rd_reg) ? job_reg.size : sz_rd_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        bins_next      = bins_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        job_next       = job_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        occ_we         = 1'b0;
        occ_wd         = rd_reg | mask;
        sz_we          = 1'b0;
        sz_wd          = max_size;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_next         = job;
                    res_next         = '0;
                    res_next.tag_out = job.tag;
                    b_next           = '0;
                    if (job.is_clear)
                    begin
                        bins_next  = '0;
                        state_next = S_RES;
                    end
                    else if (bins_reg == '0)
                    begin
                        w_next     = '0;
                        state_next = S_NEW;
                    end
                    else
                    begin
                        w_next     = job.ws;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if ((rd_reg & mask) != '0)
                begin
                    if (!last_bin)
                    begin
                        b_next     = b_reg + BIN_W'(1);
                        w_next     = job_reg.ws;
                        state_next = S_RD;
                    end
                    else if (bins_reg == CNT_W'(MAX_BINS))
                    begin
                        res_next.overflow = 1'b1;
                        state_next        = S_RES;
                    end
                    else
                    begin
                        b_next     = bins_reg[BIN_W-1:0];
                        w_next     = '0;
                        state_next = S_NEW;
                    end
                end
                else if (w_reg == job_reg.we)
                begin
                    w_next     = job_reg.ws;
                    state_next = S_MRD;
                end
                else
                begin
                    w_next     = w_reg + WIDX_W'(1);
                    state_next = S_RD;
                end
            end
            S_MRD:
            begin
                state_next = S_MWR;
            end
            S_MWR:
            begin
                occ_we = 1'b1;
                if (w_reg == job_reg.we)
                begin
                    state_next = S_SZ;
                end
                else
                begin
                    w_next     = w_reg + WIDX_W'(1);
                    state_next = S_MRD;
                end
            end
            S_SZ:
            begin
                sz_we              = 1'b1;
                res_next.bin_index = OBIN_W'(b_reg);
                res_next.bin_size  = max_size;
                state_next         = S_RES;
            end
            S_NEW:
            begin
                occ_we = 1'b1;
                occ_wd = in_range ? mask : '0;
                if (w_reg == WIDX_W'(WPB - 1))
                begin
                    sz_we               = 1'b1;
                    sz_wd               = job_reg.size;
                    bins_next           = bins_reg + CNT_W'(1);
                    res_next.bin_index  = OBIN_W'(b_reg);
                    res_next.opened_bin = 1'b1;
                    res_next.bin_size   = job_reg.size;
                    state_next          = S_RES;
                end
                else
                begin
                    w_next = w_reg + WIDX_W'(1);
                end
            end
            S_RES:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bins_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bins_reg      <= bins_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg   <= b_next;
        w_reg   <= w_next;
        job_reg <= job_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[addr] <= occ_wd;
        end
        rd_reg <= occ_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (sz_we)
        begin
            sz_mem[b_reg] <= sz_wd;
        end
        sz_rd_reg <= sz_mem[b_reg];
    end

endmodule
`default_nettype wire

[rtl/lifetime_bin_first_fit_placer_unit.sv]
// Top level of the lifetime bin first-fit placer
//
//   channel | direction | payload    | handshake
//   req     | in        | req_item_t | req_valid / req_ready
//   rsp     | out       | rsp_item_t | rsp_valid / rsp_ready
//
// A placement reads and checks each occupancy word in each scanned bin, then
// reads and rewrites each word it marks and updates the bin size, or writes all
// WPB words when it opens a bin; the occupancy memory is single-port.
// Reset empties bin count and job queue; a bin's words are rewritten on opening.
// A two-entry job queue keeps requests flowing while the result register stalls.
`default_nettype none
module lifetime_bin_first_fit_placer_unit
    import lbff_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire req_item_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_item_t      rsp
);

    logic job_valid;
    logic job_ready;
    job_t job;

    lbff_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    lbff_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

[rtl/lbff_checker.sv]
// Port-level checks of the bin placer and their binding to the top level
`default_nettype none
`include "lifetime_bin_first_fit_placer_unit_macros.svh"
module lbff_checker
    import lbff_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      req_valid,
    input wire logic      req_ready,
    input wire req_item_t req,
    input wire logic      rsp_valid,
    input wire logic      rsp_ready,
    input wire rsp_item_t rsp
);

    `LBFF_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req))
    `LBFF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
    `LBFF_ASSERT_NOW(a_ovf_zero, rsp_valid && rsp.overflow, !rsp.opened_bin && rsp.bin_index == '0 && rsp.bin_size == '0)
    `LBFF_ASSERT_NOW(a_open_no_ovf, rsp_valid && rsp.opened_bin, !rsp.overflow)

endmodule

bind lifetime_bin_first_fit_placer_unit lbff_checker u_lbff_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
`default_nettype wire
